@@ rtl/pcc_pkg.sv @@
// Shared types and constants for the printf conversion counter.
// Holds the byte class record passed from front to back and the parse phases.
// No dependencies.
`timescale 1ns / 1ps

package pcc_pkg;

    // Width of the input byte and of the emitted count
    localparam int CH_W  = 8;
    localparam int OUT_W = 16;

    // Characters with a fixed meaning in a directive
    localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CH_W-1:0] CH_PCT  = 8'h25;  // '%'
    localparam logic [CH_W-1:0] CH_STAR = 8'h2A;  // '*'
    localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;  // '.'
    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [CH_W-1:0] CH_NINE = 8'h39;  // '9'
    localparam logic [CH_W-1:0] CH_H    = 8'h68;  // 'h'
    localparam logic [CH_W-1:0] CH_L    = 8'h6C;  // 'l'

    // Decoded classes of one format byte
    typedef struct packed {
        logic term;     // string terminator
        logic pct;      // percent sign
        logic flag;     // one of "-+ #0"
        logic star;     // star width or precision
        logic digit;    // decimal digit
        logic dot;      // precision marker
        logic len_h;    // 'h'
        logic len_l;    // 'l'
        logic len_one;  // single length modifier j z t L
        logic conv;     // conversion letter other than percent
    } t_cls;

    // Position in the directive syntax
    typedef enum logic [3:0] {
        PH_TEXT  = 4'd0,
        PH_FLAGS = 4'd1,
        PH_WDIG  = 4'd2,
        PH_PREC  = 4'd3,
        PH_PDIG  = 4'd4,
        PH_H     = 4'd5,
        PH_L     = 4'd6,
        PH_CONV  = 4'd7
    } t_phase;

endpackage

@@ rtl/printf_conversion_counter.sv @@
// printf conversion counter: takes one format string byte per cycle
// while full is low and, on the zero terminator, returns the number of
// arguments the string uses (non-percent conversions plus star widths and
// precisions), clamped at 65535. Each byte gets a class decode in the
// front end and a phase transition and count update in the back end,
// with a two-entry queue between them; full rises when that queue holds
// two classes, as when a terminator waits for room in the result queue.
// A count is registered in the result queue before it shows on the result
// ports, and up to two counts wait in the output queue without stopping
// input. COUNT_BITS sets the width of the internal running count.
// Depends on pcc_pkg, pcc_front and pcc_back.
`timescale 1ns / 1ps

module printf_conversion_counter #(
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [pcc_pkg::CH_W-1:0]   i_ch,
    output logic                       empty,
    input  logic                       pop,
    output logic [pcc_pkg::OUT_W-1:0]  o_conversion_count
);

    pcc_pkg::t_cls w_cls;
    logic          w_cls_vld;
    logic          w_cls_rdy;

    // Byte decode and class queue
    pcc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_ch      (i_ch),
        .o_full    (full),
        .o_cls     (w_cls),
        .o_cls_vld (w_cls_vld),
        .i_cls_rdy (w_cls_rdy)
    );

    // Directive parser, counter and result queue
    pcc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cls              (w_cls),
        .i_cls_vld          (w_cls_vld),
        .o_cls_rdy          (w_cls_rdy),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_conversion_count (o_conversion_count)
    );

endmodule

@@ rtl/pcc_front.sv @@
// Front end of the printf conversion counter: accepts format bytes,
// decodes each into a class record and queues it for the back end.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [pcc_pkg::CH_W-1:0]  i_ch,
    output logic                      o_full,
    output pcc_pkg::t_cls             o_cls,
    output logic                      o_cls_vld,
    input  logic                      i_cls_rdy
);

    pcc_pkg::t_cls r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_qcnt;

    pcc_pkg::t_cls n_cls;
    logic          w_wr;
    logic          w_rd;

    // Byte decode
    always_comb begin
        n_cls         = '0;
        n_cls.term    = (i_ch == pcc_pkg::CH_NUL);
        n_cls.pct     = (i_ch == pcc_pkg::CH_PCT);
        n_cls.star    = (i_ch == pcc_pkg::CH_STAR);
        n_cls.dot     = (i_ch == pcc_pkg::CH_DOT);
        n_cls.digit   = (i_ch >= pcc_pkg::CH_ZERO) && (i_ch <= pcc_pkg::CH_NINE);
        n_cls.len_h   = (i_ch == pcc_pkg::CH_H);
        n_cls.len_l   = (i_ch == pcc_pkg::CH_L);
        unique case (i_ch) inside
            "-", "+", " ", "#", "0": n_cls.flag = 1'b1;
            default:                 n_cls.flag = 1'b0;
        endcase
        unique case (i_ch) inside
            "j", "z", "t", "L": n_cls.len_one = 1'b1;
            default:            n_cls.len_one = 1'b0;
        endcase
        unique case (i_ch) inside
            "d", "i", "o", "u", "x", "X", "f", "F", "e", "E",
            "g", "G", "a", "A", "c", "s", "p", "n":
                     n_cls.conv = 1'b1;
            default: n_cls.conv = 1'b0;
        endcase
    end

    // Two-entry class queue
    assign o_full    = (r_qcnt == 2'd2);
    assign o_cls_vld = (r_qcnt != 2'd0);
    assign o_cls     = r_q[r_rp];
    assign w_wr      = i_push && !o_full;
    assign w_rd      = o_cls_vld && i_cls_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_qcnt <= r_qcnt + 2'd1;
                2'b01:   r_qcnt <= r_qcnt - 2'd1;
                default: r_qcnt <= r_qcnt;
            endcase
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= n_cls;
        end
    end

`ifndef SYNTHESIS
    a_qcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 2'd2)
        else $error("class queue count out of range");

    a_qcnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_qcnt == $past(r_qcnt) + 2'd1))
        else $error("class queue did not grow on write");

    a_qcnt_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr) |=> (r_qcnt == $past(r_qcnt) - 2'd1))
        else $error("class queue did not shrink on read");
`endif

endmodule

@@ rtl/pcc_back.sv @@
// Back end of the printf conversion counter: walks the directive syntax
// on decoded byte classes, keeps the saturating count and queues results.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pcc_pkg::t_cls              i_cls,
    input  logic                       i_cls_vld,
    output logic                       o_cls_rdy,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [pcc_pkg::OUT_W-1:0]  o_conversion_count
);

    pcc_pkg::t_phase        r_phase;
    pcc_pkg::t_phase        n_phase;
    logic [COUNT_BITS-1:0]  r_count;
    logic [COUNT_BITS-1:0]  n_count;

    logic [pcc_pkg::OUT_W-1:0] r_res [2];
    logic                      r_wp;
    logic                      r_rp;
    logic [1:0]                r_rcnt;

    logic                      w_acc;
    logic                      w_term;
    logic                      w_res_wr;
    logic                      w_res_rd;
    logic                      w_bump;
    logic                      w_cot_bump;
    pcc_pkg::t_phase           w_lc_phase;
    logic                      w_lc_bump;
    logic [pcc_pkg::OUT_W-1:0] w_sat;

    // A terminator needs room in the result queue; other bytes always go
    assign o_cls_rdy = !i_cls.term || (r_rcnt != 2'd2);
    assign w_acc     = i_cls_vld && o_cls_rdy;
    assign w_term    = w_acc && i_cls.term;

    // Emitted value clamps at the output width
    generate
        if (COUNT_BITS > pcc_pkg::OUT_W) begin : g_wide
            assign w_sat = (|r_count[COUNT_BITS-1:pcc_pkg::OUT_W]) ? '1
                         : r_count[pcc_pkg::OUT_W-1:0];
        end else if (COUNT_BITS == pcc_pkg::OUT_W) begin : g_same
            assign w_sat = r_count;
        end else begin : g_narrow
            assign w_sat = {{(pcc_pkg::OUT_W-COUNT_BITS){1'b0}}, r_count};
        end
    endgenerate

    // Shared exits: conversion check, and length modifier then conversion
    always_comb begin
        w_cot_bump = i_cls.conv;
        if (i_cls.len_h) begin
            w_lc_phase = pcc_pkg::PH_H;
            w_lc_bump  = 1'b0;
        end else if (i_cls.len_l) begin
            w_lc_phase = pcc_pkg::PH_L;
            w_lc_bump  = 1'b0;
        end else if (i_cls.len_one) begin
            w_lc_phase = pcc_pkg::PH_CONV;
            w_lc_bump  = 1'b0;
        end else begin
            w_lc_phase = pcc_pkg::PH_TEXT;
            w_lc_bump  = w_cot_bump;
        end
    end

    // Parse phase next state
    always_comb begin
        n_phase = r_phase;
        w_bump  = 1'b0;
        unique case (r_phase)
            pcc_pkg::PH_TEXT: begin
                n_phase = i_cls.pct ? pcc_pkg::PH_FLAGS : pcc_pkg::PH_TEXT;
            end
            pcc_pkg::PH_FLAGS: begin
                if (i_cls.flag) begin
                    n_phase = pcc_pkg::PH_FLAGS;
                end else if (i_cls.star) begin
                    n_phase = pcc_pkg::PH_WDIG;
                    w_bump  = 1'b1;
                end else if (i_cls.digit) begin
                    n_phase = pcc_pkg::PH_WDIG;
                end else if (i_cls.dot) begin
                    n_phase = pcc_pkg::PH_PREC;
                end else begin
                    n_phase = w_lc_phase;
                    w_bump  = w_lc_bump;
                end
            end
            pcc_pkg::PH_WDIG: begin
                if (i_cls.digit) begin
                    n_phase = pcc_pkg::PH_WDIG;
                end else if (i_cls.dot) begin
                    n_phase = pcc_pkg::PH_PREC;
                end else begin
                    n_phase = w_lc_phase;
                    w_bump  = w_lc_bump;
                end
            end
            pcc_pkg::PH_PREC: begin
                if (i_cls.star) begin
                    n_phase = pcc_pkg::PH_PDIG;
                    w_bump  = 1'b1;
                end else if (i_cls.digit) begin
                    n_phase = pcc_pkg::PH_PDIG;
                end else begin
                    n_phase = w_lc_phase;
                    w_bump  = w_lc_bump;
                end
            end
            pcc_pkg::PH_PDIG: begin
                if (i_cls.digit) begin
                    n_phase = pcc_pkg::PH_PDIG;
                end else begin
                    n_phase = w_lc_phase;
                    w_bump  = w_lc_bump;
                end
            end
            pcc_pkg::PH_H: begin
                if (i_cls.len_h) begin
                    n_phase = pcc_pkg::PH_CONV;
                end else begin
                    n_phase = pcc_pkg::PH_TEXT;
                    w_bump  = w_cot_bump;
                end
            end
            pcc_pkg::PH_L: begin
                if (i_cls.len_l) begin
                    n_phase = pcc_pkg::PH_CONV;
                end else begin
                    n_phase = pcc_pkg::PH_TEXT;
                    w_bump  = w_cot_bump;
                end
            end
            pcc_pkg::PH_CONV: begin
                n_phase = pcc_pkg::PH_TEXT;
                w_bump  = w_cot_bump;
            end
            default: begin
                n_phase = pcc_pkg::PH_TEXT;
            end
        endcase
        // Terminator drops any open directive
        if (i_cls.term) begin
            n_phase = pcc_pkg::PH_TEXT;
        end
    end

    // Saturating count, cleared on a terminator
    always_comb begin
        if (i_cls.term) begin
            n_count = '0;
        end else if (w_bump && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcc_pkg::PH_TEXT;
            r_count <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Two-entry result queue
    assign w_res_wr           = w_term;
    assign o_empty            = (r_rcnt == 2'd0);
    assign w_res_rd           = i_pop && !o_empty;
    assign o_conversion_count = r_res[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_rcnt <= 2'd0;
        end else begin
            if (w_res_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_res_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_res_wr, w_res_rd})
                2'b10:   r_rcnt <= r_rcnt + 2'd1;
                2'b01:   r_rcnt <= r_rcnt - 2'd1;
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_wr) begin
            r_res[r_wp] <= w_sat;
        end
    end

`ifndef SYNTHESIS
    a_rcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= 2'd2)
        else $error("result queue count out of range");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_term |=> (r_phase == pcc_pkg::PH_TEXT) && (r_count == '0))
        else $error("terminator did not return parser to text");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_term |=> (r_count >= $past(r_count)))
        else $error("count fell without a terminator");

    a_term_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_term && !w_res_rd) |=> (r_rcnt == $past(r_rcnt) + 2'd1))
        else $error("terminator did not queue a result");
`endif

endmodule

@@ bench/printf_conversion_counter_test.sv @@
// Self-checking testbench for printf_conversion_counter: streams format strings
// byte by byte and checks every emitted argument count against a typed count or a local parser.
// Depends on pcc_pkg and printf_conversion_counter from the rtl folder.
`timescale 1ns / 1ps

module printf_conversion_counter_test;

    localparam int IDLE_LIMIT = 5000;   // cycles with no item moving on either side
    localparam int RAND_ITEMS = 420;
    localparam int AFTER_WAIT = 8;
    localparam int USE_MODEL  = -1;     // row has no typed count, use the parser mirror

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [pcc_pkg::CH_W-1:0]  i_ch;
    logic                      empty;
    logic                      pop;
    logic [pcc_pkg::OUT_W-1:0] o_conversion_count;

    printf_conversion_counter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_ch               (i_ch),
        .empty              (empty),
        .pop                (pop),
        .o_conversion_count (o_conversion_count)
    );

    // Directed strings; the terminator is appended by the sender
    string dir_text  [7] = '{"", "%*.*hhd", "%q\377", "%*", "%lll", "\001%%%Lf", "%#x"};
    int    dir_count [7] = '{0,  3,         0,        1,    0,      1,           USE_MODEL};

    string flag_set = "-+ #0";
    string conv_set = "diouxXfFeEgGaAcspn%";

    // Parser mirror state and pending counts
    pcc_pkg::t_phase           phase_now;
    logic [pcc_pkg::OUT_W-1:0] arg_tally;
    logic [pcc_pkg::OUT_W-1:0] due_counts [$];
    logic [pcc_pkg::OUT_W-1:0] want_count;
    logic [pcc_pkg::OUT_W-1:0] peak_count;

    int err_count;
    int strings_sent;
    int bytes_sent;
    int counts_seen;
    int idle_cycles;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_digit(logic [7:0] b);
        return b >= pcc_pkg::CH_ZERO && b <= pcc_pkg::CH_NINE;
    endfunction

    // Conversion letters that consume an argument (percent does not)
    function automatic bit is_conv_letter(logic [7:0] b);
        case (b) inside
            "d", "i", "o", "u", "x", "X", "f", "F", "e", "E",
            "g", "G", "a", "A", "c", "s", "p", "n": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Length modifier start; anything else ends the directive
    function automatic pcc_pkg::t_phase length_step(logic [7:0] b);
        case (b) inside
            pcc_pkg::CH_H:      return pcc_pkg::PH_H;
            pcc_pkg::CH_L:      return pcc_pkg::PH_L;
            "j", "z", "t", "L": return pcc_pkg::PH_CONV;
            default:            return pcc_pkg::PH_TEXT;
        endcase
    endfunction

    // One byte through the directive parser; a terminator queues the count
    task automatic advance_parser(input logic [7:0] b, input int fixed);
        pcc_pkg::t_phase nxt;
        bit              star_hit;
        if (b == pcc_pkg::CH_NUL) begin
            due_counts.push_back(fixed >= 0 ? pcc_pkg::OUT_W'(fixed) : arg_tally);
            phase_now = pcc_pkg::PH_TEXT;
            arg_tally = '0;
            return;
        end
        star_hit = 1'b0;
        case (phase_now)
            pcc_pkg::PH_TEXT: begin
                nxt = (b == pcc_pkg::CH_PCT) ? pcc_pkg::PH_FLAGS : pcc_pkg::PH_TEXT;
            end
            pcc_pkg::PH_FLAGS: begin
                if (b == "-" || b == "+" || b == " " || b == "#"
                    || b == pcc_pkg::CH_ZERO) begin
                    nxt = pcc_pkg::PH_FLAGS;
                end else if (b == pcc_pkg::CH_STAR) begin
                    star_hit = 1'b1;
                    nxt      = pcc_pkg::PH_WDIG;
                end else if (is_digit(b)) begin
                    nxt = pcc_pkg::PH_WDIG;
                end else if (b == pcc_pkg::CH_DOT) begin
                    nxt = pcc_pkg::PH_PREC;
                end else begin
                    nxt = length_step(b);
                end
            end
            pcc_pkg::PH_WDIG: begin
                if (is_digit(b)) nxt = pcc_pkg::PH_WDIG;
                else if (b == pcc_pkg::CH_DOT) nxt = pcc_pkg::PH_PREC;
                else nxt = length_step(b);
            end
            pcc_pkg::PH_PREC: begin
                if (b == pcc_pkg::CH_STAR) begin
                    star_hit = 1'b1;
                    nxt      = pcc_pkg::PH_PDIG;
                end else if (is_digit(b)) begin
                    nxt = pcc_pkg::PH_PDIG;
                end else begin
                    nxt = length_step(b);
                end
            end
            pcc_pkg::PH_PDIG: nxt = is_digit(b) ? pcc_pkg::PH_PDIG : length_step(b);
            pcc_pkg::PH_H:    nxt = (b == pcc_pkg::CH_H) ? pcc_pkg::PH_CONV : pcc_pkg::PH_TEXT;
            pcc_pkg::PH_L:    nxt = (b == pcc_pkg::CH_L) ? pcc_pkg::PH_CONV : pcc_pkg::PH_TEXT;
            default:          nxt = pcc_pkg::PH_TEXT;
        endcase
        // a directive that falls back to text counts only on a conversion letter
        if (star_hit || (phase_now != pcc_pkg::PH_TEXT && nxt == pcc_pkg::PH_TEXT
                         && is_conv_letter(b))) begin
            if (arg_tally != '1) arg_tally++;
        end
        phase_now = nxt;
    endtask

    // Push one item, with bursts and random gaps in front of it
    task automatic send_byte(input logic [7:0] b, input int fixed);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_ch <= b;
        do @(posedge i_clk); while (full !== 1'b0);
        advance_parser(b, fixed);
        bytes_sent++;
    endtask

    task automatic send_string(input logic [7:0] s [$], input int fixed);
        foreach (s[k]) send_byte(s[k], fixed);
        send_byte(pcc_pkg::CH_NUL, fixed);
        strings_sent++;
    endtask

    // Hold input until every queued count has been read back
    task automatic drain_counts();
        push <= 1'b0;
        while (due_counts.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: stretches of always-ready, coin-flip and mostly stalled
    initial begin
        int mode;
        int span;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 40);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            counts_seen++;
            if (due_counts.size() == 0) begin
                $display("%0t: unexpected count, expected none, got %0d",
                         $time, o_conversion_count);
                err_count++;
            end else begin
                want_count = due_counts.pop_front();
                if (o_conversion_count !== want_count) begin
                    $display("%0t: count mismatch, expected %0d, got %0d",
                             $time, want_count, o_conversion_count);
                    err_count++;
                end
                if (want_count > peak_count) peak_count = want_count;
            end
        end
    end

    // Watchdog on lack of progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d counts pending",
                         $time, IDLE_LIMIT, due_counts.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0] txt [$];
        int         rand_base;
        push         = 1'b0;
        i_ch         = '0;
        i_rst_n      = 1'b0;
        phase_now    = pcc_pkg::PH_TEXT;
        arg_tally    = '0;
        peak_count   = '0;
        err_count    = 0;
        strings_sent = 0;
        bytes_sent   = 0;
        counts_seen  = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: empty string, stars, syntax break, cut-off directive,
        // a third length letter, percent escapes, and the byte extremes
        for (int r = 0; r < 7; r++) begin
            txt.delete();
            for (int c = 0; c < dir_text[r].len(); c++) txt.push_back(dir_text[r][c]);
            send_string(txt, dir_count[r]);
        end
        drain_counts();

        // random strings: mostly well-formed directives, some text and breakage
        rand_base = bytes_sent;
        while (bytes_sent - rand_base < RAND_ITEMS) begin
            txt.delete();
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(1, 255)));
                end else begin
                    txt.push_back(pcc_pkg::CH_PCT);
                    repeat ($urandom_range(0, 2)) begin
                        txt.push_back(flag_set[$urandom_range(0, 4)]);
                    end
                    case ($urandom_range(0, 2))
                        1: txt.push_back(pcc_pkg::CH_STAR);
                        2: repeat ($urandom_range(1, 3))
                               txt.push_back(pcc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                        default: ;
                    endcase
                    case ($urandom_range(0, 3))
                        1: txt.push_back(pcc_pkg::CH_DOT);
                        2: begin
                            txt.push_back(pcc_pkg::CH_DOT);
                            txt.push_back(pcc_pkg::CH_STAR);
                        end
                        3: begin
                            txt.push_back(pcc_pkg::CH_DOT);
                            repeat ($urandom_range(1, 2))
                                txt.push_back(pcc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                        end
                        default: ;
                    endcase
                    case ($urandom_range(0, 8))
                        1: txt.push_back(pcc_pkg::CH_H);
                        2: begin
                            txt.push_back(pcc_pkg::CH_H);
                            txt.push_back(pcc_pkg::CH_H);
                        end
                        3: txt.push_back(pcc_pkg::CH_L);
                        4: begin
                            txt.push_back(pcc_pkg::CH_L);
                            txt.push_back(pcc_pkg::CH_L);
                        end
                        5: txt.push_back("j");
                        6: txt.push_back("z");
                        7: txt.push_back("t");
                        8: txt.push_back("L");
                        default: ;
                    endcase
                    // occasional stray length letter or bad conversion byte
                    if ($urandom_range(0, 9) == 0) begin
                        txt.push_back($urandom_range(0, 1) ? pcc_pkg::CH_H : pcc_pkg::CH_L);
                    end
                    if ($urandom_range(0, 9) == 0) txt.push_back(8'($urandom_range(1, 255)));
                    else txt.push_back(conv_set[$urandom_range(0, 18)]);
                end
            end
            // sometimes cut the string short inside a directive
            if (txt.size() > 1 && $urandom_range(0, 7) == 0) void'(txt.pop_back());
            send_string(txt, USE_MODEL);
            if (strings_sent % 20 == 0) drain_counts();
        end

        drain_counts();
        repeat (AFTER_WAIT) @(posedge i_clk);

        $display("Sent %0d format strings in %0d bytes: directed corner cases, then random.",
                 strings_sent, bytes_sent);
        $display("Checked %0d counts under input gaps and output stalls, largest %0d.",
                 counts_seen, peak_count);
        if (err_count == 0 && due_counts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
